@@ src/thth_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package thth_pkg;

    localparam int unsigned FREQ_W  = 22;
    localparam int unsigned DEG_W   = 10;
    localparam int unsigned PACK_W  = 42;
    localparam int unsigned PDATA_W = 64;
    localparam int unsigned PADDR_W = 6;

    localparam logic [DEG_W-1:0]  TEMP_BOUND  = 10'd1000;
    localparam logic [FREQ_W-1:0] HW_MAX_RST  = 22'h3FFFFF;

    typedef enum logic [1:0] {
        LVL_NONE = 2'd0,
        LVL_LOW  = 2'd1,
        LVL_MID  = 2'd2,
        LVL_HIGH = 2'd3
    } thth_level_t;

    // register index, taken from paddr[5:3]
    typedef enum logic [2:0] {
        REG_LEVEL_HIGH = 3'd0,
        REG_LEVEL_MID  = 3'd1,
        REG_LEVEL_LOW  = 3'd2,
        REG_USER_MAX   = 3'd3,
        REG_HW_MAX     = 3'd4,
        REG_HW_MIN     = 3'd5,
        REG_ENABLE     = 3'd6
    } thth_reg_t;

    typedef struct packed {
        logic [PACK_W-1:0] level_high;
        logic [PACK_W-1:0] level_mid;
        logic [PACK_W-1:0] level_low;
        logic [FREQ_W-1:0] user_ceil;
        logic [FREQ_W-1:0] hw_ceil;
        logic [FREQ_W-1:0] hw_floor;
        logic              enable;
    } thth_cfg_t;

    typedef struct packed {
        thth_level_t       throttle_level;
        logic [FREQ_W-1:0] freq_ceil;
        logic [FREQ_W-1:0] freq_floor;
        logic              level_changed;
    } thth_result_t;

    function automatic logic [FREQ_W-1:0] pk_cap(input logic [PACK_W-1:0] p);
        return p[41:20];
    endfunction

    function automatic logic [DEG_W-1:0] pk_trip(input logic [PACK_W-1:0] p);
        return p[19:10];
    endfunction

    function automatic logic [DEG_W-1:0] pk_clear(input logic [PACK_W-1:0] p);
        return p[9:0];
    endfunction

endpackage

`default_nettype wire

@@ src/thth_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface thth_in_if
    import thth_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DEG_W-1:0]  temperature;
    logic              read_ok;
    logic [FREQ_W-1:0] policy_min;

    modport source (output valid, output temperature, output read_ok,
                    output policy_min, input ready);
    modport sink   (input valid, input temperature, input read_ok,
                    input policy_min, output ready);
endinterface

interface thth_out_if
    import thth_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        throttle_level;
    logic [FREQ_W-1:0] freq_ceil;
    logic [FREQ_W-1:0] freq_floor;
    logic              level_changed;

    modport source (output valid, output throttle_level, output freq_ceil,
                    output freq_floor, output level_changed, input ready);
    modport sink   (input valid, input throttle_level, input freq_ceil,
                    input freq_floor, input level_changed, output ready);
endinterface

`default_nettype wire

@@ src/thth_rules.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One sample through the trip/clear rules and the frequency limits.
module thth_rules
    import thth_pkg::*;
(
    input  wire thth_cfg_t         cfg,
    input  wire logic [DEG_W-1:0]  temperature,
    input  wire logic              read_ok,
    input  wire logic [FREQ_W-1:0] policy_min,
    input  wire thth_level_t       level_cur,
    input  wire logic [FREQ_W-1:0] cap_cur,
    output thth_level_t            level_next,
    output logic [FREQ_W-1:0]      cap_next,
    output thth_result_t           res
);

    logic [DEG_W-1:0]  trip_lo;
    logic [DEG_W-1:0]  trip_md;
    logic [DEG_W-1:0]  trip_hi;
    logic              apply;
    logic              user_set;
    logic [FREQ_W-1:0] maxf;

    assign trip_lo = pk_trip(cfg.level_low);
    assign trip_md = pk_trip(cfg.level_mid);
    assign trip_hi = pk_trip(cfg.level_high);
    assign apply   = cfg.enable && read_ok && (temperature <= TEMP_BOUND);

    // first matching rule wins
    always_comb
    begin
        level_next = level_cur;
        cap_next   = cap_cur;
        if (apply)
        begin
            priority if (temperature >= trip_lo && temperature < trip_md
                         && level_cur == LVL_NONE)
            begin
                cap_next   = pk_cap(cfg.level_low);
                level_next = LVL_LOW;
            end
            else if (temperature <= pk_clear(cfg.level_low) && level_cur != LVL_NONE)
            begin
                level_next = LVL_NONE;
            end
            else if (temperature >= trip_md && temperature < trip_hi
                     && (level_cur == LVL_NONE || level_cur == LVL_LOW))
            begin
                cap_next   = pk_cap(cfg.level_mid);
                level_next = LVL_MID;
            end
            else if (temperature < pk_clear(cfg.level_mid)
                     && (level_cur == LVL_MID || level_cur == LVL_HIGH))
            begin
                cap_next   = pk_cap(cfg.level_low);
                level_next = LVL_LOW;
            end
            else if (temperature >= trip_hi && level_cur != LVL_HIGH)
            begin
                cap_next   = pk_cap(cfg.level_high);
                level_next = LVL_HIGH;
            end
            else if (temperature < pk_clear(cfg.level_high) && level_cur == LVL_HIGH)
            begin
                cap_next   = pk_cap(cfg.level_mid);
                level_next = LVL_MID;
            end
            else
            begin
                // no rule matched, state held
                level_next = level_cur;
            end
        end
    end

    assign user_set = (cfg.user_ceil != '0);

    always_comb
    begin
        if (level_next == LVL_NONE)
            maxf = user_set ? cfg.user_ceil : cfg.hw_ceil;
        else if (user_set && cfg.user_ceil < cap_next)
            maxf = cfg.user_ceil;
        else
            maxf = cap_next;
    end

    assign res.throttle_level = level_next;
    assign res.freq_ceil      = maxf;
    assign res.freq_floor     = (policy_min > maxf) ? cfg.hw_floor : policy_min;
    assign res.level_changed  = (level_next != level_cur);

endmodule

`default_nettype wire

@@ src/thermal_throttle_hysteresis_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Handshake       | Payload
// ---------+-----+-----------------+---------------------------------------------
// in_ch    | in  | valid / ready   | temperature[9:0], read_ok, policy_min[21:0]
// out_ch   | out | valid / ready   | throttle_level[1:0], freq_ceil[21:0],
//          |     |                 | freq_floor[21:0], level_changed
// apb      | in  | psel / penable  | paddr[5:0] (8*index), pwdata/prdata[63:0]
//
// Two register stages: an input register, then the result register. The
// rules and frequency limits sit between them, and one item is taken every
// cycle while out_ch keeps up.
// The throttle level and cap update at the edge the item enters the result
// register, so the next item already sees them.
// A stall on out_ch backs up through both stages; in_ch.ready drops only
// when both stages hold an item and the result is not being taken.
// rst_n clears the pipeline, the throttle state and the registers to their
// reset values; no clearing pass is needed.
module thermal_throttle_hysteresis_core
    import thth_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    thth_in_if.sink                 in_ch,
    thth_out_if.source              out_ch,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    // ---------------- configuration registers ----------------
    thth_cfg_t   cfg_reg;
    logic        cfg_we;
    thth_reg_t   cfg_sel;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_sel = thth_reg_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level_high <= '0;
            cfg_reg.level_mid  <= '0;
            cfg_reg.level_low  <= '0;
            cfg_reg.user_ceil  <= '0;
            cfg_reg.hw_ceil    <= HW_MAX_RST;
            cfg_reg.hw_floor   <= '0;
            cfg_reg.enable     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_sel)
                REG_LEVEL_HIGH: cfg_reg.level_high <= pwdata[PACK_W-1:0];
                REG_LEVEL_MID:  cfg_reg.level_mid  <= pwdata[PACK_W-1:0];
                REG_LEVEL_LOW:  cfg_reg.level_low  <= pwdata[PACK_W-1:0];
                REG_USER_MAX:   cfg_reg.user_ceil  <= pwdata[FREQ_W-1:0];
                REG_HW_MAX:     cfg_reg.hw_ceil    <= pwdata[FREQ_W-1:0];
                REG_HW_MIN:     cfg_reg.hw_floor   <= pwdata[FREQ_W-1:0];
                REG_ENABLE:     cfg_reg.enable     <= pwdata[0];
                default:        ;   // unmapped index, write dropped
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_LEVEL_HIGH: prdata = PDATA_W'(cfg_reg.level_high);
            REG_LEVEL_MID:  prdata = PDATA_W'(cfg_reg.level_mid);
            REG_LEVEL_LOW:  prdata = PDATA_W'(cfg_reg.level_low);
            REG_USER_MAX:   prdata = PDATA_W'(cfg_reg.user_ceil);
            REG_HW_MAX:     prdata = PDATA_W'(cfg_reg.hw_ceil);
            REG_HW_MIN:     prdata = PDATA_W'(cfg_reg.hw_floor);
            REG_ENABLE:     prdata = PDATA_W'(cfg_reg.enable);
            default:        prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_free;     // result register can take an item this cycle
    logic s1_move;      // input register hands its item on
    logic in_take;

    assign out_free     = !out_valid_reg || out_ch.ready;
    assign s1_move      = s1_valid_reg && out_free;
    assign in_ch.ready  = !s1_valid_reg || out_free;
    assign in_take      = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
                s1_valid_reg <= in_ch.valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // input register: payload only
    logic [DEG_W-1:0]  s1_temp_reg;
    logic              s1_ok_reg;
    logic [FREQ_W-1:0] s1_pmin_reg;

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_temp_reg <= in_ch.temperature;
            s1_ok_reg   <= in_ch.read_ok;
            s1_pmin_reg <= in_ch.policy_min;
        end
    end

    // ---------------- throttle state ----------------
    thth_level_t       level_reg;
    thth_level_t       level_next;
    logic [FREQ_W-1:0] cap_reg;
    logic [FREQ_W-1:0] cap_next;
    thth_result_t      res;
    logic              cfg_disable;

    thth_rules u_rules (
        .cfg         (cfg_reg),
        .temperature (s1_temp_reg),
        .read_ok     (s1_ok_reg),
        .policy_min  (s1_pmin_reg),
        .level_cur   (level_reg),
        .cap_cur     (cap_reg),
        .level_next  (level_next),
        .cap_next    (cap_next),
        .res         (res)
    );

    // writing enable = 0 drops straight to unthrottled, cap is kept
    assign cfg_disable = cfg_we && (cfg_sel == REG_ENABLE) && !pwdata[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= LVL_NONE;
            cap_reg   <= '0;
        end
        else
        begin
            if (s1_move)
                cap_reg <= cap_next;
            priority if (cfg_disable)
                level_reg <= LVL_NONE;
            else if (s1_move)
                level_reg <= level_next;
            else
                level_reg <= level_reg;
        end
    end

    // ---------------- result register ----------------
    thth_result_t out_res_reg;

    always_ff @(posedge clk)
    begin
        if (s1_move)
            out_res_reg <= res;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.throttle_level = out_res_reg.throttle_level;
    assign out_ch.freq_ceil      = out_res_reg.freq_ceil;
    assign out_ch.freq_floor     = out_res_reg.freq_floor;
    assign out_ch.level_changed  = out_res_reg.level_changed;

    // ---------------- checks ----------------
    a_disabled_unthrottled: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_reg.enable |-> level_reg == LVL_NONE)
        else $error("throttle level set while disabled");

    a_skip_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && !(cfg_reg.enable && s1_ok_reg)) |=> !out_res_reg.level_changed)
        else $error("level change flagged on a skipped sample");

    a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!s1_move && !cfg_disable) |=> $stable(level_reg) && $stable(cap_reg))
        else $error("throttle state moved without an item or a disable");

    a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> s1_valid_reg)
        else $error("accepted item lost from input register");

endmodule

`default_nettype wire

@@ dv/thermal_throttle_hysteresis_core_tb.sv @@
`timescale 1ns / 1ps

module thermal_throttle_hysteresis_core_tb;
    import thth_pkg::*;

    // Two register stages inside the block; the settle slack covers them.
    localparam int LATENCY_SLACK = 8;
    // About 1500 samples, each at worst a sender gap plus a receiver stall,
    // plus the hold-off and the register phases.
    // Taken several times over.
    localparam int CYCLE_LIMIT   = 250000;
    localparam int HOLD_CYCLES   = 60;
    localparam int SWEEP_PHASES  = 8;
    localparam int SWEEP_ITEMS   = 170;
    // Register slot with no register behind it; writes to it must be ignored.
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    thth_in_if  in_ch ();
    thth_out_if out_ch ();

    thermal_throttle_hysteresis_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the register file, as the throttle sees it.
    logic [PACK_W-1:0] cfg_high = '0;
    logic [PACK_W-1:0] cfg_mid  = '0;
    logic [PACK_W-1:0] cfg_low  = '0;
    logic [FREQ_W-1:0] cfg_user  = '0;
    logic [FREQ_W-1:0] cfg_hwmax = HW_MAX_RST;
    logic [FREQ_W-1:0] cfg_hwmin = '0;
    logic              cfg_en    = 1'b0;

    // Shadow of the throttle state.
    thth_level_t       thr_level = LVL_NONE;
    logic [FREQ_W-1:0] thr_cap   = '0;

    // Level and frequency limits still owed by the block, oldest first.
    thth_result_t      limits_due[$];

    int unsigned err_count   = 0;
    int unsigned n_samples   = 0;
    int unsigned n_results   = 0;
    int unsigned n_settings  = 0;
    int unsigned n_changes   = 0;
    int unsigned level_hits [4];
    int unsigned cycle_count = 0;

    // Sender burst control.
    int          burst_left  = 0;
    bit          no_gap      = 1'b0;

    // Receiver stall control.
    bit          rx_full     = 1'b0;
    bit          rx_hold     = 1'b0;
    logic [15:0] rx_pat      = 16'hB5A7;
    logic [6:0]  rx_tick     = '0;
    event        hold_off_ev;

    // Temperature walk: ramps up and down across the thresholds.
    int          walk_t      = 0;
    int          walk_dir    = 1;
    int          walk_top    = 120;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Throttle predictor: rule order is the priority order, first match wins.
    // ------------------------------------------------------------------
    function automatic thth_result_t throttle_predict(input logic [DEG_W-1:0] t,
                                                      input logic ok,
                                                      input logic [FREQ_W-1:0] pmin);
        thth_result_t      r;
        thth_level_t       prev;
        logic [FREQ_W-1:0] maxf;
        prev = thr_level;
        if (cfg_en && ok && t <= TEMP_BOUND)
        begin
            if (t >= cfg_low[19:10] && t < cfg_mid[19:10] && thr_level == LVL_NONE)
            begin
                thr_cap   = cfg_low[41:20];
                thr_level = LVL_LOW;
            end
            else if (t <= cfg_low[9:0] && thr_level != LVL_NONE)
            begin
                // low clear keeps the cap
                thr_level = LVL_NONE;
            end
            else if (t >= cfg_mid[19:10] && t < cfg_high[19:10] && thr_level < LVL_MID)
            begin
                thr_cap   = cfg_mid[41:20];
                thr_level = LVL_MID;
            end
            else if (t < cfg_mid[9:0] && thr_level > LVL_LOW)
            begin
                thr_cap   = cfg_low[41:20];
                thr_level = LVL_LOW;
            end
            else if (t >= cfg_high[19:10] && thr_level != LVL_HIGH)
            begin
                thr_cap   = cfg_high[41:20];
                thr_level = LVL_HIGH;
            end
            else if (t < cfg_high[9:0] && thr_level == LVL_HIGH)
            begin
                thr_cap   = cfg_mid[41:20];
                thr_level = LVL_MID;
            end
        end

        if (thr_level == LVL_NONE)
            maxf = (cfg_user != '0) ? cfg_user : cfg_hwmax;
        else if (cfg_user != '0 && cfg_user < thr_cap)
            maxf = cfg_user;
        else
            maxf = thr_cap;

        r.throttle_level = thr_level;
        r.freq_ceil      = maxf;
        r.freq_floor     = (pmin > maxf) ? cfg_hwmin : pmin;
        r.level_changed  = (thr_level != prev);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [2:0] idx, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_LEVEL_HIGH: cfg_high  = data[PACK_W-1:0];
            REG_LEVEL_MID:  cfg_mid   = data[PACK_W-1:0];
            REG_LEVEL_LOW:  cfg_low   = data[PACK_W-1:0];
            REG_USER_MAX:   cfg_user  = data[FREQ_W-1:0];
            REG_HW_MAX:     cfg_hwmax = data[FREQ_W-1:0];
            REG_HW_MIN:     cfg_hwmin = data[FREQ_W-1:0];
            REG_ENABLE:
            begin
                cfg_en = data[0];
                // disabling drops the level at once, cap is kept
                if (!data[0])
                    thr_level = LVL_NONE;
            end
            default: ;
        endcase
    endtask

    // Ends a group of writes; leaves the bus idle.
    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_settings++;
        @(posedge clk);
    endtask

    task automatic load_setting(input logic [PDATA_W-1:0] hi, input logic [PDATA_W-1:0] md,
                                input logic [PDATA_W-1:0] lo, input logic [PDATA_W-1:0] user,
                                input logic [PDATA_W-1:0] hwmax,
                                input logic [PDATA_W-1:0] hwmin,
                                input logic [PDATA_W-1:0] en);
        apb_write(REG_LEVEL_HIGH, hi);
        apb_write(REG_LEVEL_MID, md);
        apb_write(REG_LEVEL_LOW, lo);
        apb_write(REG_USER_MAX, user);
        apb_write(REG_HW_MAX, hwmax);
        apb_write(REG_HW_MIN, hwmin);
        apb_write(REG_ENABLE, en);
        apb_release();
    endtask

    function automatic logic [PDATA_W-1:0] pack_level(input int unsigned cap, input int trip,
                                                       input int clr);
        return {22'd0, cap[FREQ_W-1:0], trip[DEG_W-1:0], clr[DEG_W-1:0]};
    endfunction

    // ------------------------------------------------------------------
    // Sample sender: bursts of random length, random gaps between them.
    // ------------------------------------------------------------------
    task automatic send_sample(input logic [DEG_W-1:0] t, input logic ok,
                               input logic [FREQ_W-1:0] pmin);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = no_gap ? 0 : $urandom_range(0, 8);
            if (gap != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid       <= 1'b1;
        in_ch.temperature <= t;
        in_ch.read_ok     <= ok;
        in_ch.policy_min  <= pmin;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        limits_due.push_back(throttle_predict(t, ok, pmin));
        n_samples++;
    endtask

    // Stops sending and waits until every owed item has come back.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (limits_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY_SLACK) @(posedge clk);
    endtask

    function automatic logic [DEG_W-1:0] pick_temp();
        int r;
        int stride;
        r = $urandom_range(0, 99);
        if (r < 5)
            return DEG_W'($urandom_range(1001, 1023));
        if (r < 12)
            return DEG_W'($urandom_range(0, 1023));
        if ($urandom_range(0, 19) == 0)
            walk_dir = -walk_dir;
        stride = $urandom_range(0, 12);
        walk_t = walk_t + walk_dir * stride;
        if (walk_t >= walk_top)
        begin
            walk_t   = walk_top;
            walk_dir = -1;
        end
        if (walk_t <= 0)
        begin
            walk_t   = 0;
            walk_dir = 1;
        end
        return DEG_W'(walk_t);
    endfunction

    function automatic logic [FREQ_W-1:0] pick_pmin();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return FREQ_W'($urandom_range(0, 1500000));
            default: return FREQ_W'($urandom);
        endcase
    endfunction

    function automatic logic pick_ok();
        return $urandom_range(0, 9) != 0;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: rotating stall pattern, reloaded now and then, plus a long
    // hold-off on request and stretches at full rate.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 7'd1;
        if (rx_tick == '0)
            rx_pat <= ($urandom_range(0, 1) != 0) ? 16'($urandom | $urandom | 1)
                                                  : 16'($urandom | 1);
        else
            rx_pat <= {rx_pat[0], rx_pat[15:1]};
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= !rx_hold && (rx_full || rx_pat[0]);
    end

    initial
    begin
        forever
        begin
            @(hold_off_ev);
            rx_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result check against the oldest owed item
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] seen,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s at item %0d: got %0h, expected %0h",
                 $realtime, what, n_results, seen, want);
        err_count++;
    endtask

    always @(posedge clk)
    begin : result_check
        thth_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (limits_due.size() == 0)
            begin
                report_mismatch("unexpected item", {30'd0, out_ch.throttle_level}, 32'd0);
            end
            else
            begin
                want = limits_due.pop_front();
                if (out_ch.throttle_level !== want.throttle_level)
                    report_mismatch("throttle_level", 32'(out_ch.throttle_level),
                                    32'(want.throttle_level));
                if (out_ch.freq_ceil !== want.freq_ceil)
                    report_mismatch("freq_ceil", 32'(out_ch.freq_ceil),
                                    32'(want.freq_ceil));
                if (out_ch.freq_floor !== want.freq_floor)
                    report_mismatch("freq_floor", 32'(out_ch.freq_floor),
                                    32'(want.freq_floor));
                if (out_ch.level_changed !== want.level_changed)
                    report_mismatch("level_changed", 32'(out_ch.level_changed),
                                    32'(want.level_changed));
                level_hits[want.throttle_level]++;
                if (want.level_changed)
                    n_changes++;
            end
            n_results++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight out of reset: throttle disabled, ceiling is the hardware max.
    task automatic check_reset_values();
        send_sample(10'd1023, 1'b1, '0);
        send_sample(10'd60, 1'b1, '1);
        settle();
    endtask

    // One walk through every rule with ordered thresholds, plus the failed
    // read, the out-of-bound samples and the policy minimum extremes.
    task automatic check_rule_walk();
        load_setting(pack_level(800000, 90, 80), pack_level(1200000, 70, 60),
                     pack_level(1800000, 50, 40), 0, 2500000, 300000, 1);
        send_sample(10'd0, 1'b1, '0);
        send_sample(10'd50, 1'b1, '1);          // low trip, min falls back
        send_sample(10'd45, 1'b0, 22'd1800000); // failed read, pmin == max
        send_sample(10'd40, 1'b1, 22'd100000);  // low clear
        send_sample(10'd75, 1'b1, 22'd100000);  // mid trip straight from none
        send_sample(10'd65, 1'b1, 22'd100000);  // inside hysteresis band
        send_sample(10'd59, 1'b1, 22'd100000);  // mid clear
        send_sample(10'd95, 1'b1, 22'd100000);  // high trip
        send_sample(10'd85, 1'b1, 22'd900000);  // hold, pmin above cap
        send_sample(10'd79, 1'b1, 22'd100000);  // high clear
        send_sample(10'd1001, 1'b1, 22'd5);     // just past the bound
        send_sample(10'd1023, 1'b1, 22'd5);
        send_sample(10'd1000, 1'b1, 22'd5);     // on the bound: high trip
        send_sample(10'd30, 1'b1, 22'd5);       // low clear wins from high
        send_sample(10'd1000, 1'b0, 22'd5);
        settle();
    endtask

    task automatic check_user_ceiling();
        apb_write(REG_USER_MAX, 64'd1000000);
        apb_release();
        send_sample(10'd50, 1'b1, 22'd1200000); // user below low cap
        send_sample(10'd95, 1'b1, 22'd100);     // high cap below user
        settle();
        apb_write(REG_USER_MAX, 64'h3F_FFFF);
        apb_write(REG_HW_MAX, 64'd0);
        apb_release();
        send_sample(10'd30, 1'b1, '1);
        settle();
        apb_write(REG_USER_MAX, 64'd0);
        apb_release();
        send_sample(10'd0, 1'b1, 22'd1);        // max is zero, min falls back
        settle();
    endtask

    task automatic check_disable();
        apb_write(REG_HW_MAX, 64'd2500000);
        apb_release();
        send_sample(10'd95, 1'b1, 22'd0);
        settle();
        // level forced to none by the write itself
        apb_write(REG_ENABLE, 64'd0);
        apb_release();
        send_sample(10'd95, 1'b1, 22'd0);
        settle();
        apb_write(REG_ENABLE, 64'd1);
        apb_release();
        send_sample(10'd55, 1'b1, 22'd0);
        send_sample(10'd96, 1'b1, 22'd0);
        settle();
    endtask

    // Receiver holds off while the sender keeps offering, so both stages fill
    // and the input stalls; then the sender pauses until all has drained.
    task automatic check_backpressure();
        walk_top = 110;
        no_gap   = 1'b1;
        -> hold_off_ev;
        repeat (40) send_sample(pick_temp(), pick_ok(), pick_pmin());
        settle();
        no_gap   = 1'b0;
        repeat (20) send_sample(pick_temp(), pick_ok(), pick_pmin());
        settle();
    endtask

    task automatic random_setting(input int ph);
        int c_lo;
        int t_lo;
        int c_md;
        int t_md;
        int c_hi;
        int t_hi;
        logic [PDATA_W-1:0] user;
        c_lo = $urandom_range(0, 250);
        t_lo = c_lo + $urandom_range(1, 60);
        c_md = t_lo + $urandom_range(0, 60);
        t_md = c_md + $urandom_range(1, 60);
        c_hi = t_md + $urandom_range(0, 60);
        t_hi = c_hi + $urandom_range(1, 60);
        user = ($urandom_range(0, 2) == 0) ? 64'd0 : 64'($urandom);
        walk_top = t_hi + 40;
        case (ph)
            0:
            begin
                // every bit set, above the bound in all trips
                load_setting('1, '1, '1, '1, '1, '1, '1);
                walk_top = 1023;
            end
            1:
            begin
                load_setting('0, '0, '0, '1, '0, '0, 64'd1);
                walk_top = 200;
            end
            7:
            begin
                // unordered thresholds: only rule priority decides
                load_setting({$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom}, user, 64'($urandom),
                             64'($urandom), 64'd1);
                walk_top = 1023;
            end
            default:
            begin
                load_setting(pack_level($urandom, t_hi, c_hi),
                             pack_level($urandom, t_md, c_md),
                             pack_level($urandom, t_lo, c_lo),
                             user, 64'($urandom), 64'($urandom),
                             (ph == 5) ? 64'd0 : 64'd1);
            end
        endcase
        if (ph == 6)
        begin
            apb_write(REG_UNUSED, {$urandom, $urandom});
            apb_release();
        end
    endtask

    task automatic check_random_sweep();
        for (int ph = 0; ph < SWEEP_PHASES; ph++)
        begin
            random_setting(ph);
            walk_t  = 0;
            // one phase at full rate on both sides
            no_gap  = (ph == 3);
            rx_full = (ph == 3);
            repeat (SWEEP_ITEMS) send_sample(pick_temp(), pick_ok(), pick_pmin());
            settle();
        end
        no_gap  = 1'b0;
        rx_full = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------
    initial
    begin
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.temperature  <= '0;
        in_ch.read_ok      <= 1'b0;
        in_ch.policy_min   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_reset_values();
        check_rule_walk();
        check_user_ceiling();
        check_disable();
        check_backpressure();
        check_random_sweep();

        settle();
        $display("Sent %0d samples over %0d register settings;", n_samples, n_settings);
        $display("%0d items checked, %0d level changes; per level: none %0d, low %0d, mid %0d, high %0d",
                 n_results, n_changes, level_hits[0], level_hits[1], level_hits[2],
                 level_hits[3]);
        if (err_count == 0 && limits_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ thermal_throttle_hysteresis_core.f @@
src/thth_pkg.sv
src/thth_if.sv
src/thth_rules.sv
src/thermal_throttle_hysteresis_core.sv
dv/thermal_throttle_hysteresis_core_tb.sv
